// ----- hw/rtl/dibhv_pkg.sv -----
// Shared types and constants for the bitmap info header validator.
// Used by dibhv_regs, dib_header_validator_top and the bench; no dependencies.
package dibhv_pkg;

    localparam int IN_DATA_W  = 384;
    localparam int OUT_DATA_W = 128;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_MAX_INPUT_BYTES = 2'd0;
    localparam logic [1:0] REG_MAX_DIMENSION   = 2'd1;
    localparam logic [1:0] REG_MAX_PIXEL_COUNT = 2'd2;

    localparam logic [31:0] RST_MAX_INPUT_BYTES = 32'd67108864;
    localparam logic [30:0] RST_MAX_DIMENSION   = 31'd16384;
    localparam logic [31:0] RST_MAX_PIXEL_COUNT = 32'd268435456;

    localparam logic [31:0] HDR_V3      = 32'd40;
    localparam logic [31:0] HDR_V2      = 32'd52;
    localparam logic [31:0] HDR_V3_ALPHA = 32'd56;
    localparam logic [31:0] HDR_V4      = 32'd108;
    localparam logic [31:0] HDR_V5      = 32'd124;

    localparam logic [31:0] COMP_RGB        = 32'd0;
    localparam logic [31:0] COMP_BITFIELDS  = 32'd3;
    localparam logic [31:0] COMP_ABITFIELDS = 32'd6;

    localparam logic [31:0] MAX_PALETTE = 32'd256;
    localparam logic [31:0] HEIGHT_MIN  = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] max_input_bytes;
        logic [30:0] max_dimension;
        logic [31:0] max_pixel_count;
    } limits_t;

endpackage

// ----- hw/rtl/dibhv_regs.sv -----
// Configuration registers of the header validator behind an APB-style port.
// Depends on dibhv_pkg for the register map, reset values and limits_t.
module dibhv_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dibhv_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dibhv_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dibhv_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    output dibhv_pkg::limits_t                 limits
);
    import dibhv_pkg::*;

    logic [31:0] max_input_bytes_reg;
    logic [30:0] max_dimension_reg;
    logic [31:0] max_pixel_count_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_input_bytes_reg <= RST_MAX_INPUT_BYTES;
            max_dimension_reg   <= RST_MAX_DIMENSION;
            max_pixel_count_reg <= RST_MAX_PIXEL_COUNT;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_MAX_INPUT_BYTES: max_input_bytes_reg <= pwdata;
                REG_MAX_DIMENSION:   max_dimension_reg   <= pwdata[30:0];
                REG_MAX_PIXEL_COUNT: max_pixel_count_reg <= pwdata;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MAX_INPUT_BYTES: prdata = max_input_bytes_reg;
            REG_MAX_DIMENSION:   prdata = {1'b0, max_dimension_reg};
            REG_MAX_PIXEL_COUNT: prdata = max_pixel_count_reg;
            default:             prdata = '0;
        endcase
    end

    assign limits.max_input_bytes = max_input_bytes_reg;
    assign limits.max_dimension   = max_dimension_reg;
    assign limits.max_pixel_count = max_pixel_count_reg;

endmodule

// ----- hw/rtl/dib_header_validator_top.sv -----
// Top level of the bitmap info header validator: a four-stage check pipeline.
// Depends on dibhv_pkg and instantiates dibhv_regs for the limit registers.
//
// One request on the slave stream carries the decoded fields of one info header
// plus the total buffer length; require_v5 travels in s_tuser. For every request
// exactly one result leaves on the master stream: m_tuser carries the valid flag
// and m_tdata the pixel data offset, pixel byte count, width and absolute height,
// all zero when the header is rejected.
// m_tvalid rises once the request has passed the four register stages (field
// checks, palette and mask checks with row stride, the two multipliers, and the
// final size compares). A new request can be taken every cycle while s_tready
// is high; the rate is one per cycle. Each stage holds its request while the
// next one is full, so a stalled receiver fills the pipeline and s_tready falls
// only when all four stages hold data; nothing is dropped or repeated.
// Reset empties the pipeline and loads the limits with their defaults. Limits
// are to be written over the APB port only while no request is in flight; the
// block itself does not enforce this.
module dib_header_validator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // byte_count, header_size, width, height, planes, bit_depth, compression,
    // colors_used, image_size, masks_red_green, masks_blue_alpha
    input  logic [dibhv_pkg::IN_DATA_W-1:0]     s_tdata,
    // require_v5
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // bits_offset, pixel_bytes, width_out, height_out, zero fill
    output logic [dibhv_pkg::OUT_DATA_W-1:0]    m_tdata,
    // valid_res
    output logic [0:0]                          m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dibhv_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [dibhv_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dibhv_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import dibhv_pkg::*;

    limits_t lim;

    dibhv_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limits  (lim)
    );

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage 1: field decode and the plain header checks.
    logic [31:0] in_total, in_hs, in_width, in_height, in_comp, in_cu, in_isize;
    logic [15:0] in_planes, in_depth;
    logic [31:0] in_m0, in_m1, in_m2, in_m3;
    logic        in_v5, hs_ok, depth_ok, c_plain, c_bf, c_abf, c_fields;
    logic [31:0] h_abs;
    logic        err1_next;

    assign in_total  = s_tdata[31:0];
    assign in_hs     = s_tdata[63:32];
    assign in_width  = s_tdata[95:64];
    assign in_height = s_tdata[127:96];
    assign in_planes = s_tdata[143:128];
    assign in_depth  = s_tdata[159:144];
    assign in_comp   = s_tdata[191:160];
    assign in_cu     = s_tdata[223:192];
    assign in_isize  = s_tdata[255:224];
    assign in_m0     = s_tdata[287:256];
    assign in_m1     = s_tdata[319:288];
    assign in_m2     = s_tdata[351:320];
    assign in_m3     = s_tdata[383:352];
    assign in_v5     = s_tuser[0];

    assign hs_ok = (in_hs == HDR_V3) || (in_hs == HDR_V2) || (in_hs == HDR_V3_ALPHA)
                || (in_hs == HDR_V4) || (in_hs == HDR_V5);
    assign depth_ok = (in_depth == 16'd1) || (in_depth == 16'd4) || (in_depth == 16'd8)
                   || (in_depth == 16'd16) || (in_depth == 16'd24) || (in_depth == 16'd32);
    assign c_plain  = in_comp == COMP_RGB;
    assign c_bf     = in_comp == COMP_BITFIELDS;
    assign c_abf    = in_comp == COMP_ABITFIELDS;
    assign c_fields = c_bf || c_abf;
    assign h_abs    = in_height[31] ? (~in_height + 32'd1) : in_height;

    assign err1_next = (in_total < HDR_V3) || (in_total > lim.max_input_bytes)
                    || !hs_ok || (in_hs > in_total) || (in_v5 && (in_hs != HDR_V5))
                    || in_width[31] || (in_width == '0) || (in_height == '0)
                    || (in_height == HEIGHT_MIN) || (in_planes != 16'd1) || !depth_ok
                    || !(c_plain || c_fields)
                    || (c_fields && (in_depth != 16'd16) && (in_depth != 16'd32))
                    || (c_abf && ((in_hs < HDR_V3_ALPHA) || in_height[31]));

    logic        s1_err_reg, s1_fields_reg, s1_abf_reg;
    logic [31:0] s1_total_reg, s1_cu_reg, s1_isize_reg;
    logic [6:0]  s1_hs_reg;
    logic [5:0]  s1_depth_reg;
    logic [31:0] s1_m0_reg, s1_m1_reg, s1_m2_reg, s1_m3_reg;
    logic [30:0] s1_w_reg, s1_h_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_err_reg    <= err1_next;
            s1_fields_reg <= c_fields;
            s1_abf_reg    <= c_abf;
            s1_total_reg  <= in_total;
            s1_cu_reg     <= in_cu;
            s1_isize_reg  <= in_isize;
            s1_hs_reg     <= in_hs[6:0];
            s1_depth_reg  <= in_depth[5:0];
            s1_m0_reg     <= in_m0;
            s1_m1_reg     <= in_m1;
            s1_m2_reg     <= in_m2;
            s1_m3_reg     <= in_m3;
            s1_w_reg      <= in_width[30:0];
            s1_h_reg      <= h_abs[30:0];
        end
    end

    // Stage 2: dimension, palette and mask checks, offset and row stride.
    logic [8:0]  full_pal;
    logic [31:0] cu_sel;
    logic        pal_err, mask_err, dim_err, err2_next;
    logic [7:0]  off_hdr;
    logic [10:0] offpal_next;
    logic [35:0] wbits;
    logic [36:0] wbits_rnd;
    logic [31:0] row_words;
    logic        row_big_next;
    logic [31:0] row_lo_next;

    assign dim_err = ({1'b0, s1_w_reg} > {1'b0, lim.max_dimension})
                  || ({1'b0, s1_h_reg} > {1'b0, lim.max_dimension});

    always_comb
    begin
        full_pal = 9'd1 << s1_depth_reg[3:0];
        if (s1_depth_reg <= 6'd8)
        begin
            cu_sel  = (s1_cu_reg == '0) ? {23'd0, full_pal} : s1_cu_reg;
            pal_err = cu_sel > {23'd0, full_pal};
        end
        else
        begin
            cu_sel  = s1_cu_reg;
            pal_err = s1_cu_reg > MAX_PALETTE;
        end
    end

    always_comb
    begin
        mask_err = 1'b0;
        if (s1_fields_reg)
        begin
            mask_err = (s1_abf_reg ? (s1_total_reg < HDR_V3_ALPHA)
                                   : (s1_total_reg < HDR_V2))
                    || (s1_m0_reg == '0) || (s1_m1_reg == '0) || (s1_m2_reg == '0)
                    || ((s1_m0_reg & s1_m1_reg) != '0)
                    || ((s1_m0_reg & s1_m2_reg) != '0)
                    || ((s1_m1_reg & s1_m2_reg) != '0)
                    || ((s1_depth_reg == 6'd16)
                        && ((s1_m0_reg[31:16] | s1_m1_reg[31:16] | s1_m2_reg[31:16])
                            != '0));
            if (s1_abf_reg)
            begin
                mask_err = mask_err || (s1_m3_reg == '0)
                        || (((s1_m0_reg | s1_m1_reg | s1_m2_reg) & s1_m3_reg) != '0)
                        || ((s1_depth_reg == 6'd16) && (s1_m3_reg[31:16] != '0));
            end
        end
    end

    always_comb
    begin
        off_hdr = {1'b0, s1_hs_reg};
        if (s1_fields_reg && (s1_hs_reg == HDR_V3[6:0]))
        begin
            off_hdr = s1_abf_reg ? 8'd56 : 8'd52;
        end
        offpal_next = {3'd0, off_hdr} + {cu_sel[8:0], 2'b00};
    end

    always_comb
    begin
        case (s1_depth_reg)
            6'd1:    wbits = {5'd0, s1_w_reg};
            6'd4:    wbits = {3'd0, s1_w_reg, 2'd0};
            6'd8:    wbits = {2'd0, s1_w_reg, 3'd0};
            6'd16:   wbits = {1'd0, s1_w_reg, 4'd0};
            6'd24:   wbits = {1'd0, s1_w_reg, 4'd0} + {2'd0, s1_w_reg, 3'd0};
            6'd32:   wbits = {s1_w_reg, 5'd0};
            default: wbits = '0;
        endcase
        wbits_rnd    = {1'b0, wbits} + 37'd31;
        row_words    = wbits_rnd[36:5];
        row_big_next = row_words[31:30] != 2'b00;
        row_lo_next  = {row_words[29:0], 2'b00};
    end

    assign err2_next = s1_err_reg || dim_err || pal_err || mask_err;

    logic        s2_err_reg, s2_row_big_reg;
    logic [31:0] s2_total_reg, s2_isize_reg, s2_row_reg;
    logic [10:0] s2_offpal_reg;
    logic [30:0] s2_w_reg, s2_h_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_err_reg     <= err2_next;
            s2_row_big_reg <= row_big_next;
            s2_total_reg   <= s1_total_reg;
            s2_isize_reg   <= s1_isize_reg;
            s2_row_reg     <= row_lo_next;
            s2_offpal_reg  <= offpal_next;
            s2_w_reg       <= s1_w_reg;
            s2_h_reg       <= s1_h_reg;
        end
    end

    // Stage 3: pixel count and pixel byte products, remaining room.
    logic [61:0] wh_next;
    logic [62:0] pix_next;
    logic        err3_next;
    logic [31:0] room_next;

    assign wh_next   = {31'd0, s2_w_reg} * {31'd0, s2_h_reg};
    assign pix_next  = {31'd0, s2_row_reg} * {32'd0, s2_h_reg};
    assign err3_next = s2_err_reg || s2_row_big_reg
                    || ({21'd0, s2_offpal_reg} > s2_total_reg);
    assign room_next = s2_total_reg - {21'd0, s2_offpal_reg};

    logic        s3_err_reg;
    logic [61:0] s3_wh_reg;
    logic [62:0] s3_pix_reg;
    logic [31:0] s3_room_reg, s3_isize_reg;
    logic [10:0] s3_offpal_reg;
    logic [30:0] s3_w_reg, s3_h_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_err_reg    <= err3_next;
            s3_wh_reg     <= wh_next;
            s3_pix_reg    <= pix_next;
            s3_room_reg   <= room_next;
            s3_isize_reg  <= s2_isize_reg;
            s3_offpal_reg <= s2_offpal_reg;
            s3_w_reg      <= s2_w_reg;
            s3_h_reg      <= s2_h_reg;
        end
    end

    // Stage 4: size compares and the result register.
    logic        fail;
    logic [OUT_DATA_W-1:0] out_data_next;

    assign fail = s3_err_reg
               || (s3_wh_reg > {30'd0, lim.max_pixel_count})
               || (s3_pix_reg > {31'd0, s3_room_reg})
               || ((s3_isize_reg != '0)
                   && (({31'd0, s3_isize_reg} < s3_pix_reg)
                       || (s3_isize_reg > s3_room_reg)));

    assign out_data_next = fail ? '0
                         : {2'd0, s3_h_reg, s3_w_reg, s3_pix_reg[31:0],
                            21'd0, s3_offpal_reg};

    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_ok_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            out_data_reg <= out_data_next;
            out_ok_reg   <= !fail;
        end
    end

    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_ok_reg;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for dib_header_validator_top: streams bitmap info headers, predicts
// each verdict on its own and compares every field of every result in arrival order.
// Depends on dibhv_pkg and the validator RTL only.
module tb;
    import dibhv_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PIPE_DEPTH  = 4;

    typedef struct {
        logic [31:0] byte_count;
        logic [31:0] header_size;
        logic [31:0] width;
        logic [31:0] height;
        logic [15:0] planes;
        logic [15:0] bit_depth;
        logic [31:0] compression;
        logic [31:0] colors_used;
        logic [31:0] image_size;
        logic [63:0] masks_rg;
        logic [63:0] masks_ba;
        logic        require_v5;
    } dib_hdr_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] bits_offset;
        logic [31:0] pixel_bytes;
        logic [30:0] width_out;
        logic [30:0] height_out;
    } verdict_t;

    typedef enum int {
        FAULT_TOTAL,
        FAULT_HEADER,
        FAULT_V5,
        FAULT_WIDTH,
        FAULT_HEIGHT,
        FAULT_PLANES,
        FAULT_DEPTH,
        FAULT_COMP,
        FAULT_PALETTE,
        FAULT_IMAGE_SIZE,
        FAULT_MASK_ZERO,
        FAULT_MASK_OVERLAP,
        FAULT_MASK_WIDE,
        FAULT_COUNT
    } fault_e;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic [31:0] lim_bytes;
    logic [30:0] lim_dim;
    logic [31:0] lim_pixels;

    verdict_t expected_verdicts[$];
    int       mismatches = 0;
    int       cycle_count = 0;
    bit       idle_on = 1'b1;

    dib_header_validator_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic verdict_t judge_header(dib_hdr_t h);
        verdict_t    v;
        logic [31:0] m[4];
        logic [31:0] allowed;
        logic [31:0] habs;
        logic [63:0] total;
        logic [63:0] cnt;
        logic [63:0] full;
        logic [63:0] nmask;
        logic [63:0] off;
        logic [63:0] pal;
        logic [63:0] row;
        logic [63:0] pix;
        logic [63:0] room;
        logic        fields;
        logic        hneg;
        logic        ok;
        total  = {32'd0, h.byte_count};
        fields = h.compression == COMP_BITFIELDS || h.compression == COMP_ABITFIELDS;
        nmask  = (h.compression == COMP_ABITFIELDS) ? 64'd4 : 64'd3;
        hneg   = h.height[31];
        habs   = hneg ? -h.height : h.height;
        m[0]   = h.masks_rg[31:0];
        m[1]   = h.masks_rg[63:32];
        m[2]   = h.masks_ba[31:0];
        m[3]   = h.masks_ba[63:32];
        ok     = 1'b1;
        if (h.byte_count < HDR_V3 || h.byte_count > lim_bytes)
            ok = 1'b0;
        if (!(h.header_size == HDR_V3 || h.header_size == HDR_V2 ||
              h.header_size == HDR_V3_ALPHA || h.header_size == HDR_V4 ||
              h.header_size == HDR_V5))
            ok = 1'b0;
        if (h.header_size > h.byte_count || (h.require_v5 && h.header_size != HDR_V5))
            ok = 1'b0;
        if (h.width[31] || h.width == 32'd0 || h.height == 32'd0 || h.height == HEIGHT_MIN)
            ok = 1'b0;
        if (h.planes != 16'd1)
            ok = 1'b0;
        if (!(h.bit_depth == 16'd1 || h.bit_depth == 16'd4 || h.bit_depth == 16'd8 ||
              h.bit_depth == 16'd16 || h.bit_depth == 16'd24 || h.bit_depth == 16'd32))
            ok = 1'b0;
        if (h.compression != COMP_RGB && !fields)
            ok = 1'b0;
        if (fields && h.bit_depth != 16'd16 && h.bit_depth != 16'd32)
            ok = 1'b0;
        if (h.compression == COMP_ABITFIELDS && (h.header_size < HDR_V3_ALPHA || hneg))
            ok = 1'b0;
        if (h.width > {1'b0, lim_dim} || habs > {1'b0, lim_dim})
            ok = 1'b0;
        if ({32'd0, h.width} * {32'd0, habs} > {32'd0, lim_pixels})
            ok = 1'b0;
        cnt = {32'd0, h.colors_used};
        if (h.bit_depth <= 16'd8)
        begin
            full = 64'd1 << h.bit_depth;
            if (cnt == 64'd0)
                cnt = full;
            if (cnt > full)
                ok = 1'b0;
        end
        else if (cnt > {32'd0, MAX_PALETTE})
            ok = 1'b0;
        if (fields)
        begin
            if (64'd40 + 64'd4 * nmask > total)
                ok = 1'b0;
            allowed = (h.bit_depth >= 16'd32) ? 32'hFFFF_FFFF
                                              : (32'd1 << h.bit_depth[4:0]) - 32'd1;
            for (int i = 0; i < nmask; i++)
            begin
                if (m[i] == 32'd0 || (m[i] & ~allowed) != 32'd0)
                    ok = 1'b0;
                for (int j = i + 1; j < nmask; j++)
                    if ((m[i] & m[j]) != 32'd0)
                        ok = 1'b0;
            end
        end
        off = {32'd0, h.header_size} +
              ((h.header_size == HDR_V3 && fields) ? 64'd4 * nmask : 64'd0);
        pal = 64'd4 * cnt;
        if (off > total || pal > total || off + pal > total)
            ok = 1'b0;
        off  = off + pal;
        row  = (({32'd0, h.width} * h.bit_depth + 64'd31) / 64'd32) * 64'd4;
        pix  = row * {32'd0, habs};
        room = total - off;
        if (pix > room)
            ok = 1'b0;
        if (h.image_size != 32'd0 &&
            ({32'd0, h.image_size} < pix || {32'd0, h.image_size} > room))
            ok = 1'b0;
        v = '0;
        if (ok)
        begin
            v.ok          = 1'b1;
            v.bits_offset = off[31:0];
            v.pixel_bytes = pix[31:0];
            v.width_out   = h.width[30:0];
            v.height_out  = habs[30:0];
        end
        return v;
    endfunction

    // Builds a self-consistent header: masks, palette and pixel data fit the buffer,
    // with slack spare bytes, possibly none, at the end.
    function automatic dib_hdr_t lay_out_header(logic [31:0] hs, logic [15:0] depth,
            logic [31:0] comp, int w, int hgt, logic [31:0] colors, int slack);
        dib_hdr_t    h;
        logic [31:0] m[4];
        int          nmask;
        int          owner;
        bit          fields;
        longint      cnt;
        longint      off;
        longint      row;
        longint      pix;
        longint      ha;
        longint      wl;
        longint      dl;
        fields = comp == COMP_BITFIELDS || comp == COMP_ABITFIELDS;
        nmask  = (comp == COMP_ABITFIELDS) ? 4 : 3;
        for (int i = 0; i < 4; i++)
            m[i] = 32'd0;
        for (int b = 0; b < 32; b++)
        begin
            owner = (b < nmask) ? b : $urandom_range(0, nmask);
            if (b < depth && owner < nmask)
                m[owner][b] = 1'b1;
        end
        if (nmask == 3)
            m[3] = $urandom;
        h.header_size = hs;
        h.bit_depth   = depth;
        h.compression = comp;
        h.width       = w;
        h.height      = hgt;
        h.planes      = 16'd1;
        h.colors_used = colors;
        h.require_v5  = 1'b0;
        if (fields)
        begin
            h.masks_rg = {m[1], m[0]};
            h.masks_ba = {m[3], m[2]};
        end
        else
        begin
            h.masks_rg = {$urandom, $urandom};
            h.masks_ba = {$urandom, $urandom};
        end
        cnt = longint'(colors);
        if (depth <= 16'd8 && colors == 32'd0)
            cnt = 64'd1 << depth;
        off = hs + ((hs == HDR_V3 && fields) ? 4 * nmask : 0) + 4 * cnt;
        wl  = longint'(w);
        dl  = longint'(depth);
        ha  = (hgt < 0) ? -longint'(hgt) : longint'(hgt);
        row = ((wl * dl + 31) / 32) * 4;
        pix = row * ha;
        h.byte_count = 32'(off + pix + slack);
        case ($urandom_range(0, 3))
            1: h.image_size = 32'(pix);
            2: h.image_size = 32'(pix + $urandom_range(0, slack));
            default: h.image_size = 32'd0;
        endcase
        return h;
    endfunction

    function automatic dib_hdr_t random_header(int max_side);
        logic [31:0] hs;
        logic [31:0] comp;
        logic [15:0] depth;
        logic [31:0] colors;
        int          w;
        int          hgt;
        int          slack;
        bit          v5;
        dib_hdr_t    h;
        case ($urandom_range(0, 4))
            0: hs = HDR_V3;
            1: hs = HDR_V2;
            2: hs = HDR_V3_ALPHA;
            3: hs = HDR_V4;
            default: hs = HDR_V5;
        endcase
        v5 = ($urandom_range(0, 7) == 0);
        if (v5)
            hs = HDR_V5;
        case ($urandom_range(0, 5))
            0: comp = COMP_BITFIELDS;
            1: comp = (hs < HDR_V3_ALPHA) ? COMP_BITFIELDS : COMP_ABITFIELDS;
            default: comp = COMP_RGB;
        endcase
        if (comp != COMP_RGB)
            depth = $urandom_range(0, 1) ? 16'd16 : 16'd32;
        else
            case ($urandom_range(0, 5))
                0: depth = 16'd1;
                1: depth = 16'd4;
                2: depth = 16'd8;
                3: depth = 16'd16;
                4: depth = 16'd24;
                default: depth = 16'd32;
            endcase
        w   = $urandom_range(1, max_side);
        hgt = $urandom_range(1, max_side);
        if (comp != COMP_ABITFIELDS && $urandom_range(0, 2) == 0)
            hgt = -hgt;
        if (depth <= 16'd8)
            colors = $urandom_range(0, 32'd1 << depth);
        else
            colors = ($urandom_range(0, 9) == 0) ? MAX_PALETTE : $urandom_range(0, 6);
        slack = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 64);
        h = lay_out_header(hs, depth, comp, w, hgt, colors, slack);
        h.require_v5 = v5;
        return h;
    endfunction

    function automatic dib_hdr_t break_header(dib_hdr_t h);
        fault_e fault;
        fault = fault_e'($urandom_range(0, FAULT_COUNT - 1));
        case (fault)
            FAULT_TOTAL:
                h.byte_count = $urandom_range(0, 1) ? h.byte_count - 32'd1
                                                    : $urandom_range(0, 60);
            FAULT_HEADER:
                h.header_size = $urandom_range(0, 1) ? $urandom_range(0, 130) : $urandom;
            FAULT_V5:
                h.require_v5 = ~h.require_v5;
            FAULT_WIDTH:
                h.width = $urandom_range(0, 1) ? 32'd0 : ($urandom | 32'h8000_0000);
            FAULT_HEIGHT:
                case ($urandom_range(0, 2))
                    0: h.height = 32'd0;
                    1: h.height = HEIGHT_MIN;
                    default: h.height = -h.height;
                endcase
            FAULT_PLANES:
                h.planes = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(2, 65535));
            FAULT_DEPTH:
                h.bit_depth = 16'($urandom_range(0, 40));
            FAULT_COMP:
                h.compression = $urandom_range(0, 7);
            FAULT_PALETTE:
                h.colors_used = h.colors_used + $urandom_range(1, 300);
            FAULT_IMAGE_SIZE:
                h.image_size = $urandom_range(1, h.byte_count);
            FAULT_MASK_ZERO:
                case ($urandom_range(0, 3))
                    0: h.masks_rg[31:0]  = 32'd0;
                    1: h.masks_rg[63:32] = 32'd0;
                    2: h.masks_ba[31:0]  = 32'd0;
                    default: h.masks_ba[63:32] = 32'd0;
                endcase
            FAULT_MASK_OVERLAP:
                h.masks_rg[63:32] = h.masks_rg[63:32] | h.masks_rg[31:0];
            default:
                h.masks_ba[31:0] = h.masks_ba[31:0] | (32'd1 << $urandom_range(16, 31));
        endcase
        return h;
    endfunction

    task automatic send_header(dib_hdr_t h);
        int gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {h.masks_ba, h.masks_rg, h.image_size, h.colors_used, h.compression,
                     h.bit_depth, h.planes, h.height, h.width, h.header_size, h.byte_count};
        s_tuser  <= h.require_v5;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        expected_verdicts.push_back(judge_header(h));
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(logic [1:0] index, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_MAX_INPUT_BYTES: lim_bytes = value;
            REG_MAX_DIMENSION:   lim_dim = value[30:0];
            REG_MAX_PIXEL_COUNT: lim_pixels = value;
            default: ;
        endcase
    endtask

    task automatic set_limits(logic [31:0] bytes, logic [31:0] dim, logic [31:0] pixels);
        drain_results();
        write_limit(REG_MAX_INPUT_BYTES, bytes);
        write_limit(REG_MAX_DIMENSION, dim);
        write_limit(REG_MAX_PIXEL_COUNT, pixels);
    endtask

    task automatic test_directed_cases();
        dib_hdr_t h;
        h = lay_out_header(HDR_V3, 16'd24, COMP_RGB, 1, 1, 32'd0, 0);
        h.image_size = 32'd0;
        send_header(h);
        h.byte_count = 32'd39;
        send_header(h);
        h.byte_count = 32'hFFFF_FFFF;
        send_header(h);
        h = lay_out_header(HDR_V5, 16'd32, COMP_RGB, 3, -2, 32'd0, 0);
        h.require_v5 = 1'b1;
        send_header(h);
        h = lay_out_header(HDR_V4, 16'd24, COMP_RGB, 5, 5, 32'd0, 8);
        h.require_v5 = 1'b1;
        send_header(h);
        send_header(lay_out_header(HDR_V2, 16'd1, COMP_RGB, 9, 3, 32'd0, 0));
        send_header(lay_out_header(HDR_V3, 16'd4, COMP_RGB, 7, 2, 32'd0, 4));
        send_header(lay_out_header(HDR_V3, 16'd8, COMP_RGB, 3, 3, 32'd257, 0));
        send_header(lay_out_header(HDR_V3, 16'd16, COMP_BITFIELDS, 4, 4, 32'd0, 0));
        send_header(lay_out_header(HDR_V3_ALPHA, 16'd32, COMP_ABITFIELDS, 2, 2, 32'd0, 0));
        send_header(lay_out_header(HDR_V2, 16'd32, COMP_ABITFIELDS, 2, 2, 32'd0, 0));
        send_header(lay_out_header(HDR_V4, 16'd32, COMP_ABITFIELDS, 2, -2, 32'd0, 0));
        h = lay_out_header(HDR_V4, 16'd16, COMP_BITFIELDS, 6, 1, 32'd0, 0);
        h.masks_rg[63:32] = h.masks_rg[31:0];
        send_header(h);
        h = lay_out_header(HDR_V4, 16'd16, COMP_BITFIELDS, 6, 1, 32'd0, 0);
        h.masks_ba[31:0] = 32'd0;
        send_header(h);
        h = lay_out_header(HDR_V4, 16'd16, COMP_BITFIELDS, 6, 1, 32'd0, 0);
        h.masks_ba[31] = 1'b1;
        send_header(h);
        h = lay_out_header(HDR_V3, 16'd24, COMP_RGB, 2, 2, 32'd0, 0);
        h.width = 32'hFFFF_FFFE;
        send_header(h);
        h.width = 32'd0;
        send_header(h);
        h.width  = 32'd2;
        h.height = HEIGHT_MIN;
        send_header(h);
        h.height = 32'd0;
        send_header(h);
        h.height = 32'd2;
        h.planes = 16'd0;
        send_header(h);
        h.planes    = 16'd1;
        h.bit_depth = 16'd2;
        send_header(h);
        h.bit_depth   = 16'd24;
        h.compression = 32'd1;
        send_header(h);
        send_header(lay_out_header(HDR_V4, 16'd24, COMP_RGB, 3, 3, MAX_PALETTE, 0));
        h = lay_out_header(HDR_V3, 16'd24, COMP_RGB, 5, 3, 32'd0, 12);
        h.image_size = 32'd48;
        send_header(h);
        h.image_size = 32'd47;
        send_header(h);
        h.image_size = 32'd61;
        send_header(h);
        h = lay_out_header(HDR_V3, 16'd1, COMP_RGB, 16385, 1, 32'd0, 0);
        send_header(h);
        h = lay_out_header(HDR_V3, 16'd1, COMP_RGB, 16384, 1, 32'd0, 0);
        h.byte_count = h.byte_count - 32'd1;
        send_header(h);
    endtask

    task automatic test_random_headers();
        dib_hdr_t h;
        for (int n = 0; n < 400; n++)
        begin
            if (n % 50 == 0)
                idle_on = ((n / 50) % 3) != 2;
            if (n == 200)
                drain_results();
            h = random_header(($urandom_range(0, 19) == 0) ? 400 : 40);
            if ($urandom_range(0, 9) < 3)
                h = break_header(h);
            send_header(h);
        end
        idle_on = 1'b1;
    endtask

    task automatic test_limit_settings();
        set_limits(32'd0, 32'd0, 32'd0);
        repeat (15) send_header(random_header(40));
        set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_header(lay_out_header(HDR_V3, 16'd1, COMP_RGB, 100000, 2, 32'd0, 0));
        send_header(lay_out_header(HDR_V3, 16'd32, COMP_RGB, 32'h7FFF_FFFF, 1, 32'd0, 0));
        repeat (15) send_header(random_header(40));
        set_limits(32'd3000, 32'd24, 32'd300);
        send_header(lay_out_header(HDR_V3, 16'd8, COMP_RGB, 24, 12, 32'd1, 0));
        send_header(lay_out_header(HDR_V3, 16'd8, COMP_RGB, 25, 12, 32'd1, 0));
        send_header(lay_out_header(HDR_V3, 16'd8, COMP_RGB, 12, -24, 32'd1, 0));
        send_header(lay_out_header(HDR_V3, 16'd8, COMP_RGB, 13, 24, 32'd1, 0));
        repeat (30) send_header(random_header(30));
        set_limits(RST_MAX_INPUT_BYTES, {1'b0, RST_MAX_DIMENSION}, RST_MAX_PIXEL_COUNT);
    endtask

    task automatic test_noise();
        dib_hdr_t h;
        repeat (50)
        begin
            h.byte_count  = $urandom;
            h.header_size = $urandom;
            h.width       = $urandom;
            h.height      = $urandom;
            h.planes      = 16'($urandom);
            h.bit_depth   = 16'($urandom);
            h.compression = $urandom;
            h.colors_used = $urandom;
            h.image_size  = $urandom;
            h.masks_rg    = {$urandom, $urandom};
            h.masks_ba    = {$urandom, $urandom};
            h.require_v5  = 1'($urandom_range(0, 1));
            send_header(h);
        end
    endtask

    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            stall = idle_on ? $urandom_range(0, 19) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin : check_results
        verdict_t seen;
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.ok          = m_tuser[0];
            seen.bits_offset = m_tdata[31:0];
            seen.pixel_bytes = m_tdata[63:32];
            seen.width_out   = m_tdata[94:64];
            seen.height_out  = m_tdata[125:95];
            if (expected_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: valid %0d offset %0d bytes %0d w %0d h %0d",
                             seen.ok, seen.bits_offset, seen.pixel_bytes,
                             seen.width_out, seen.height_out);
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (seen.ok != want.ok || seen.bits_offset != want.bits_offset ||
                    seen.pixel_bytes != want.pixel_bytes ||
                    seen.width_out != want.width_out || seen.height_out != want.height_out)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected valid %0d offset %0d bytes %0d w %0d h %0d",
                                 want.ok, want.bits_offset, want.pixel_bytes,
                                 want.width_out, want.height_out);
                        $display("          got      valid %0d offset %0d bytes %0d w %0d h %0d",
                                 seen.ok, seen.bits_offset, seen.pixel_bytes,
                                 seen.width_out, seen.height_out);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        lim_bytes  = RST_MAX_INPUT_BYTES;
        lim_dim    = RST_MAX_DIMENSION;
        lim_pixels = RST_MAX_PIXEL_COUNT;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_random_headers();
        test_limit_settings();
        test_noise();
        drain_results();
        repeat (2 * PIPE_DEPTH) @(posedge clk);
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
